// File: rtl/mwo_pkg.sv
// Shared types, constants and helpers for the multi-waveform oscillator.
package mwo_pkg;

  localparam int SINE_TABLE_ENTRIES_DEF = 256;
  localparam int SAMPLE_WIDTH_DEF       = 16;

  localparam int RATE_W  = 18;
  localparam int WAVE_W  = 3;
  localparam int INDEX_W = 32;
  localparam int CHAN_W  = 4;
  localparam int FREQ_W  = 20;
  localparam int CFG_IDX_W = 2;

  // divider operand widths: dividend covers F*t, divisor covers 16*fs
  localparam int DIV_W = 52;
  localparam int DEN_W = 22;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
  localparam logic [15:0]       NOISE_SEED = 16'hACE1;
  localparam logic [15:0]       NOISE_TAPS = 16'hB400;
  localparam logic [DEN_W-1:0]  NOISE_DIV  = 22'd65535;

  localparam logic [31:0] K1  = 32'd1686629713;
  localparam logic [31:0] K3  = 32'd693598668;
  localparam logic [31:0] K5  = 32'd85569306;
  localparam logic [31:0] K7  = 32'd5026995;
  localparam logic [31:0] K9  = 32'd172272;
  localparam logic [31:0] K11 = 32'd3864;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_WAVE_SELECT = 2'd1
  } cfg_reg_t;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SINE_MOD,
    S_SINE_POS,
    S_SINE_ANG,
    S_SINE_POLY,
    S_PERIOD,
    S_PHASE,
    S_SCALE,
    S_NOISE,
    S_FINISH
  } osc_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DEN_W-1:0] remainder;
  } div_rsp_t;

  // Horner coefficient used at polynomial step 1..5
  function automatic logic [31:0] poly_coef(input logic [2:0] step);
    logic [31:0] c;
    begin
      unique case (step)
        3'd1:    c = K9;
        3'd2:    c = K7;
        3'd3:    c = K5;
        3'd4:    c = K3;
        3'd5:    c = K1;
        default: c = '0;
      endcase
      return c;
    end
  endfunction

endpackage

// File: rtl/mwo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module mwo_div (
  input  logic             clk,
  input  logic             rst,
  input  mwo_pkg::div_req_t req,
  output mwo_pkg::div_rsp_t rsp
);
  import mwo_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DEN_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   shifted;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[DIV_W-1]};
    fits     = shifted >= {1'b0, dvs};
    diff     = shifted - {1'b0, dvs};
    rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= '0;
        quo   <= req.dividend;
        dvs   <= req.divisor;
        count <= CNT_W'(DIV_W - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_W-2:0], fits};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: rtl/mwo_poly.sv
// Quarter-wave sine polynomial, one shared multiplier stepped over the squaring and Horner steps.
module mwo_poly (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] angle,
  output logic        done,
  output logic [31:0] value
);
  import mwo_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd6;

  logic        busy;
  logic [2:0]  step;
  logic [31:0] a_reg;
  logic [31:0] a2;
  logic [31:0] acc;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  always_comb begin
    op_a = a2;
    op_b = acc;
    if (step == '0) begin
      op_a = a_reg;
      op_b = a_reg;
    end else if (step == LAST_STEP) begin
      op_a = a_reg;
    end else if (step == 3'd1) begin
      op_b = K11;
    end
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= {1'b0, angle};
        step  <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (step == '0) begin
          a2 <= prod[61:30];
        end else if (step == LAST_STEP) begin
          value <= prod[61:30];
          busy  <= 1'b0;
          done  <= 1'b1;
        end else begin
          acc <= poly_coef(step) - prod[61:30];
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

// File: rtl/multi_waveform_oscillator.sv
// Multi-waveform oscillator: sequencer over a serial divider and sine polynomial.
// Zero frequency goes straight to the output; noise takes one divide, square two,
//   sawtooth and triangle three, sine three divides in the bit-serial divider and
//   then the polynomial. One item at a time.
// Throughput: a new transaction is taken once the previous one has reached
//   the output register. Reset: sample_rate 44100, wave_select sine, noise 0xACE1.
module multi_waveform_oscillator #(
  parameter int SINE_TABLE_ENTRIES = mwo_pkg::SINE_TABLE_ENTRIES_DEF,
  parameter int SAMPLE_WIDTH       = mwo_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwo_pkg::RATE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mwo_pkg::INDEX_W-1:0]     sample_index,
  input  logic [mwo_pkg::CHAN_W-1:0]      channel,
  input  logic [mwo_pkg::FREQ_W-1:0]      tone_frequency,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_value,
  output logic [mwo_pkg::CHAN_W-1:0]      channel_tag,
  output logic                            bad_frequency
);
  import mwo_pkg::*;

  localparam int N    = SINE_TABLE_ENTRIES;
  localparam int NW   = $clog2(N) + 1;
  localparam int SW   = SAMPLE_WIDTH;
  localparam int SH   = 31 - SW;
  localparam logic [SW-1:0] FS_MAX = SW'((64'd1 << (SW - 1)) - 64'd1);

  osc_state_t state, state_next;

  logic [RATE_W-1:0]  sample_rate;
  logic [WAVE_W-1:0]  wave_select;
  logic [15:0]        lfsr;
  logic [INDEX_W-1:0] t_reg;
  logic [CHAN_W-1:0]  chan_reg;
  logic [FREQ_W-1:0]  f_reg;
  logic [DEN_W-1:0]   den_reg;
  logic [DEN_W-1:0]   t0_reg;
  logic [1:0]         quad_reg;
  logic               neg_reg;
  logic signed [SW-1:0] res_val;
  logic               res_bad;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     poly_start;
  logic     poly_done;
  logic [31:0] poly_value;
  logic     result_load;

  logic [RATE_W-1:0] fs_eff;
  logic [DEN_W-1:0]  den;
  logic              in_take;
  logic [15:0]       lfsr_next;
  logic [DEN_W-1:0]  t0_calc;
  logic [NW-1:0]     pos;
  logic [NW+1:0]     q4;
  logic [1:0]        quad;
  logic [NW+1:0]     off;
  logic [NW+1:0]     num;
  logic [DEN_W-1:0]  m;
  logic              low_half;
  logic signed [25:0] diff;
  logic [25:0]       diff_abs;
  logic [SW:0]       scaled;
  logic [32:0]       round_sum;
  logic [32:0]       sine_mag;
  logic [SW-1:0]     sine_clip;

  mwo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mwo_poly u_poly (
    .clk   (clk),
    .rst   (rst),
    .start (poly_start),
    .angle (div_rsp.quotient[30:0]),
    .done  (poly_done),
    .value (poly_value)
  );

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // datapath helpers
  always_comb begin
    fs_eff    = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
    den       = {fs_eff, 4'b0000};
    lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? NOISE_TAPS : 16'h0000);

    t0_calc = (div_rsp.quotient[DEN_W-1:0] == '0) ? DEN_W'(1)
                                                  : div_rsp.quotient[DEN_W-1:0];

    pos = div_rsp.quotient[NW-1:0];
    q4  = {pos, 2'b00};
    if (q4 >= (NW+2)'(3 * N)) begin
      quad = 2'd3;
    end else if (q4 >= (NW+2)'(2 * N)) begin
      quad = 2'd2;
    end else if (q4 >= (NW+2)'(N)) begin
      quad = 2'd1;
    end else begin
      quad = 2'd0;
    end
    off = q4 - (NW+2)'(quad) * (NW+2)'(N);
    num = quad[0] ? ((NW+2)'(N) - off) : off;

    m        = div_rsp.remainder;
    low_half = m < (t0_reg >> 1);
    if (wave_select == WAVE_SAW) begin
      diff = $signed({4'b0, t0_reg}) - $signed({3'b0, m, 1'b0});
    end else if (low_half) begin
      diff = $signed({2'b0, m, 2'b00}) - $signed({4'b0, t0_reg});
    end else begin
      diff = $signed({3'b0, t0_reg, 1'b0}) + $signed({4'b0, t0_reg})
           - $signed({2'b0, m, 2'b00});
    end
    diff_abs = diff[25] ? 26'(-diff) : 26'(diff);

    scaled    = div_rsp.quotient[SW:0];
    round_sum = {1'b0, poly_value} + (33'd1 << (SH - 1));
    sine_mag  = round_sum >> SH;
    sine_clip = (sine_mag > 33'(FS_MAX)) ? FS_MAX : sine_mag[SW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_take) state_next = S_LOAD;
      S_LOAD: begin
        if (f_reg == '0) begin
          state_next = S_FINISH;
        end else if (wave_select == WAVE_SAW || wave_select == WAVE_SQUARE ||
                     wave_select == WAVE_TRIANGLE) begin
          state_next = S_PERIOD;
        end else if (wave_select == WAVE_NOISE) begin
          state_next = S_NOISE;
        end else begin
          state_next = S_SINE_MOD;
        end
      end
      S_SINE_MOD:  if (div_rsp.done) state_next = S_SINE_POS;
      S_SINE_POS:  if (div_rsp.done) state_next = S_SINE_ANG;
      S_SINE_ANG:  if (div_rsp.done) state_next = S_SINE_POLY;
      S_SINE_POLY: if (poly_done) state_next = S_FINISH;
      S_PERIOD:    if (div_rsp.done) state_next = S_PHASE;
      S_PHASE: begin
        if (div_rsp.done) begin
          state_next = (wave_select == WAVE_SQUARE) ? S_FINISH : S_SCALE;
        end
      end
      S_SCALE:     if (div_rsp.done) state_next = S_FINISH;
      S_NOISE:     if (div_rsp.done) state_next = S_FINISH;
      S_FINISH:    if (result_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req     = '0;
    poly_start  = 1'b0;
    result_load = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (f_reg != '0) begin
          div_req.start = 1'b1;
          if (wave_select == WAVE_SAW || wave_select == WAVE_SQUARE ||
              wave_select == WAVE_TRIANGLE) begin
            div_req.dividend = DIV_W'(den_reg);
            div_req.divisor  = DEN_W'(f_reg);
          end else if (wave_select == WAVE_NOISE) begin
            div_req.dividend = DIV_W'(lfsr_next) * DIV_W'(FS_MAX);
            div_req.divisor  = NOISE_DIV;
          end else begin
            div_req.dividend = DIV_W'(f_reg) * DIV_W'(t_reg);
            div_req.divisor  = den_reg;
          end
        end
      end
      S_SINE_MOD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(div_rsp.remainder) * DIV_W'(N);
          div_req.divisor  = den_reg;
        end
      end
      S_SINE_POS: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(num) << 30;
          div_req.divisor  = DEN_W'(N);
        end
      end
      S_SINE_ANG:  poly_start = div_rsp.done;
      S_PERIOD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(t_reg);
          div_req.divisor  = t0_calc;
        end
      end
      S_PHASE: begin
        if (div_rsp.done && wave_select != WAVE_SQUARE) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(diff_abs) << (SW - 1);
          div_req.divisor  = t0_reg;
        end
      end
      S_FINISH:    result_load = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sample_rate <= RATE_RESET;
      wave_select <= WAVE_SINE;
      lfsr        <= NOISE_SEED;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_SAMPLE_RATE) begin
          sample_rate <= cfg_data;
        end else if (cfg_index == REG_WAVE_SELECT) begin
          wave_select <= cfg_data[WAVE_W-1:0];
        end
      end
      if (state == S_LOAD && f_reg != '0 && wave_select == WAVE_NOISE) begin
        lfsr <= lfsr_next;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      t_reg    <= sample_index;
      chan_reg <= channel;
      f_reg    <= tone_frequency;
      den_reg  <= den;
    end
    unique case (state)
      S_LOAD: begin
        res_bad <= (f_reg == '0);
        res_val <= '0;
      end
      S_SINE_POS:  if (div_rsp.done) quad_reg <= quad;
      S_SINE_POLY: begin
        if (poly_done) res_val <= quad_reg[1] ? SW'(-sine_clip) : sine_clip;
      end
      S_PERIOD:    if (div_rsp.done) t0_reg <= t0_calc;
      S_PHASE: begin
        if (div_rsp.done) begin
          neg_reg <= diff[25];
          res_val <= low_half ? FS_MAX : ~FS_MAX;
        end
      end
      S_SCALE: begin
        if (div_rsp.done) begin
          if (neg_reg) begin
            res_val <= SW'(-scaled);
          end else begin
            res_val <= (scaled > (SW+1)'(FS_MAX)) ? FS_MAX : scaled[SW-1:0];
          end
        end
      end
      S_NOISE:     if (div_rsp.done) res_val <= div_rsp.quotient[SW-1:0];
      default: begin
      end
    endcase
    if (result_load) begin
      sample_value  <= res_val;
      channel_tag   <= chan_reg;
      bad_frequency <= res_bad;
    end
  end

endmodule
